@@ src/sprite_sheet_frame_select_core_assert.svh @@
// Assertion macros for the sprite sheet frame select core.
`ifndef SPRITE_SHEET_FRAME_SELECT_CORE_ASSERT_SVH
`define SPRITE_SHEET_FRAME_SELECT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define SSFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssfs assertion failed");
// next-cycle implication
`define SSFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssfs assertion failed");
`else
`define SSFS_ASSERT_IMP(lbl, ante, cons)
`define SSFS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/ssfs_pkg.sv @@
// Types, widths and codes shared by the sprite sheet frame select core.
package ssfs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_FRAMES = 1024;

    localparam int TIME_W    = 32;
    localparam int UV_W      = 17;
    localparam int XY_W      = 18;
    localparam int FRAME_W   = 10;
    localparam int FC_W      = 11;
    localparam int FPS_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 11;

    localparam int POS_W = TIME_W + FPS_W + 1;
    localparam int HI_W  = POS_W - FRAC_BITS;
    localparam int DV_W  = FC_W + 1;

    localparam int MOD_STEPS  = 7;
    localparam int MOD_GROUPS = (HI_W + MOD_STEPS - 1) / MOD_STEPS;
    localparam int MOD_NUM_W  = MOD_GROUPS * MOD_STEPS;

    localparam int DIM_STEPS  = 7;
    localparam int DIM_GROUPS = (UV_W + DIM_STEPS - 1) / DIM_STEPS;
    localparam int DIM_NUM_W  = DIM_GROUPS * DIM_STEPS;

    localparam int FDIV_STEPS  = 5;
    localparam int FDIV_GROUPS = (FRAME_W + FDIV_STEPS - 1) / FDIV_STEPS;
    localparam int FDIV_NUM_W  = FDIV_GROUPS * FDIV_STEPS;

    localparam int PROD_W  = FRAME_W + UV_W;
    localparam int XYSUM_W = PROD_W + 1;

    localparam logic [XY_W-1:0] XY_MAX = '1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_CLAMP,
        MODE_LOOP,
        MODE_PINGPONG
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_FCOUNT,
        CFG_FPS,
        CFG_COLS,
        CFG_ROWS
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] time_q16;
        logic [UV_W-1:0]          uv_x;
        logic [UV_W-1:0]          uv_y;
        logic [UV_W-1:0]          uv_width;
        logic [UV_W-1:0]          uv_height;
    } item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_row;
        logic [FRAME_W-1:0] frame_column;
        logic [XY_W-1:0]    out_x;
        logic [XY_W-1:0]    out_y;
        logic [UV_W-1:0]    out_width;
        logic [UV_W-1:0]    out_height;
    } result_t;

    // everything one request carries down the pipe
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic                    neg;
        logic                    lo_nz;
        logic [FRAME_W-1:0]      cf;
        logic [DV_W-1:0]         mrem;
        logic [MOD_NUM_W-1:0]    mnum;
        logic [FC_W-1:0]         frem;
        logic [FDIV_NUM_W-1:0]   fnum;
        logic [FC_W-1:0]         wrem;
        logic [DIM_NUM_W-1:0]    wnum;
        logic [FC_W-1:0]         hrem;
        logic [DIM_NUM_W-1:0]    hnum;
        logic [UV_W-1:0]         ux;
        logic [UV_W-1:0]         uy;
        logic [UV_W-1:0]         uw;
        logic [UV_W-1:0]         uh;
        logic [PROD_W-1:0]       px;
        logic [PROD_W-1:0]       py;
        result_t                 res;
    } pipe_t;

endpackage

@@ src/ssfs_div_steps.sv @@
// A few restoring division steps: shifts dividend bits into the remainder.
module ssfs_div_steps
    import ssfs_pkg::*;
#(
    parameter int NUM_W = MOD_NUM_W,
    parameter int DEN_W = DV_W,
    parameter int STEPS = MOD_STEPS
) (
    input  logic [DEN_W-1:0] rem_in,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den,
    output logic [DEN_W-1:0] rem_out,
    output logic [NUM_W-1:0] num_out
);

    logic [DEN_W-1:0] rem_v;
    logic [NUM_W-1:0] num_v;
    logic [DEN_W:0]   trial;

    // quotient bits replace dividend bits at the low end of num
    always_comb
    begin
        rem_v = rem_in;
        num_v = num_in;
        trial = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            trial = {rem_v, num_v[NUM_W-1]};
            num_v = {num_v[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den})
            begin
                rem_v    = DEN_W'(trial - {1'b0, den});
                num_v[0] = 1'b1;
            end
            else
            begin
                rem_v = trial[DEN_W-1:0];
            end
        end
    end

    assign rem_out = rem_v;
    assign num_out = num_v;

endmodule

@@ src/sprite_sheet_frame_select_core.sv @@
// Top level of the sprite sheet frame select core: config registers and pipeline.
//
// Requests arrive on item (item_valid/item_ready) carrying a Q16.16 time and an
// atlas UV rectangle; each request yields exactly one result on result
// (result_valid/result_ready) with the sheet row, column and frame sub-rectangle.
// Results leave in request order.
// Pipeline: 11 register stages, one request per cycle sustained while result_ready
// stays high. The depth comes from the time-by-rate multiply, the floored
// modulo over the frame count (doubled in ping-pong; restoring divider, 7 bits
// per stage), the frame-to-row/column divider and the offset multiply; the
// width/height dividers run alongside.
// Each stage keeps its own valid bit; a stage accepts when it is empty or the
// stage after it moves, so while the receiver stalls, upstream bubbles keep
// filling and item_ready drops only when every stage holds a request.
// Config writes (cfg_valid/cfg_ready, always ready) go to the register picked
// by cfg_index; write them only with the pipe empty.
// Reset clears all valid bits and loads mode none, frame count 0, rate 0 and
// column/row counts of 1. There is no clearing pass.
`include "sprite_sheet_frame_select_core_assert.svh"

module sprite_sheet_frame_select_core
    import ssfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int S_MUL   = 0;
    localparam int S_PREP  = 1;
    localparam int S_MOD0  = 2;
    localparam int S_FOLD  = S_MOD0 + MOD_GROUPS;
    localparam int S_FDIV0 = S_FOLD + 1;
    localparam int S_MUL2  = S_FDIV0 + FDIV_GROUPS;
    localparam int S_OUT   = S_MUL2 + 1;
    localparam int NS      = S_OUT + 1;

    mode_t             mode_reg;
    logic [FC_W-1:0]   fcount_reg;
    logic [FPS_W-1:0]  fps_reg;
    logic [FC_W-1:0]   cols_reg;
    logic [FC_W-1:0]   rows_reg;

    logic [FC_W-1:0]    fcs;
    logic [FRAME_W-1:0] fcs_m1;
    logic [DV_W-1:0]    dv_eff;
    logic [FC_W-1:0]    cols_eff;
    logic [FC_W-1:0]    rows_eff;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] vin;
    logic [NS:0]   rdy;
    pipe_t         item_reg  [NS];
    pipe_t         item_next [NS];

    logic [DV_W-1:0]       mod_rem_o [MOD_GROUPS];
    logic [MOD_NUM_W-1:0]  mod_num_o [MOD_GROUPS];
    logic [FC_W-1:0]       w_rem_o   [DIM_GROUPS];
    logic [DIM_NUM_W-1:0]  w_num_o   [DIM_GROUPS];
    logic [FC_W-1:0]       h_rem_o   [DIM_GROUPS];
    logic [DIM_NUM_W-1:0]  h_num_o   [DIM_GROUPS];
    logic [FC_W-1:0]       f_rem_o   [FDIV_GROUPS];
    logic [FDIV_NUM_W-1:0] f_num_o   [FDIV_GROUPS];

    logic [HI_W-1:0]    p_hi;
    logic [HI_W-1:0]    p_mag;
    logic [DV_W-1:0]    fm;
    logic [DV_W-1:0]    fold_f;
    logic [XYSUM_W-1:0] sum_x;
    logic [XYSUM_W-1:0] sum_y;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            fcount_reg <= '0;
            fps_reg    <= '0;
            cols_reg   <= FC_W'(1);
            rows_reg   <= FC_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                CFG_FCOUNT: fcount_reg <= cfg_data[FC_W-1:0];
                CFG_FPS:    fps_reg    <= cfg_data[FPS_W-1:0];
                CFG_COLS:   cols_reg   <= cfg_data[FC_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_data[FC_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign fcs      = (fcount_reg > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : fcount_reg;
    assign fcs_m1   = (fcs == '0) ? '0 : FRAME_W'(fcs - FC_W'(1));
    assign cols_eff = (cols_reg == '0) ? FC_W'(1) : cols_reg;
    assign rows_eff = (rows_reg == '0) ? FC_W'(1) : rows_reg;
    assign dv_eff   = (fcs == '0) ? DV_W'(1) :
                      (mode_reg == MODE_PINGPONG) ? {fcs, 1'b0} : DV_W'(fcs);

    // handshake chain
    assign vin = {valid_reg[NS-2:0], item_valid};

    always_comb
    begin
        rdy[NS] = result_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= vin[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (rdy[k] && vin[k])
            begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    assign item_ready   = rdy[0];
    assign result_valid = valid_reg[NS-1];
    assign result       = item_reg[NS-1].res;

    // stage 0: frame position = time * rate
    always_comb
    begin
        item_next[S_MUL]      = '0;
        item_next[S_MUL].pos  = POS_W'(item.time_q16) * POS_W'($signed({1'b0, fps_reg}));
        item_next[S_MUL].ux   = item.uv_x;
        item_next[S_MUL].uy   = item.uv_y;
        item_next[S_MUL].uw   = item.uv_width;
        item_next[S_MUL].uh   = item.uv_height;
        item_next[S_MUL].wnum = DIM_NUM_W'(item.uv_width);
        item_next[S_MUL].hnum = DIM_NUM_W'(item.uv_height);
    end

    // width / height dividers, one group per stage starting at stage 1
    for (genvar g = 0; g < DIM_GROUPS; g++)
    begin : g_dim_div
        ssfs_div_steps #(
            .NUM_W (DIM_NUM_W),
            .DEN_W (FC_W),
            .STEPS (DIM_STEPS)
        ) u_wdiv (
            .rem_in  (item_reg[g].wrem),
            .num_in  (item_reg[g].wnum),
            .den     (cols_eff),
            .rem_out (w_rem_o[g]),
            .num_out (w_num_o[g])
        );

        ssfs_div_steps #(
            .NUM_W (DIM_NUM_W),
            .DEN_W (FC_W),
            .STEPS (DIM_STEPS)
        ) u_hdiv (
            .rem_in  (item_reg[g].hrem),
            .num_in  (item_reg[g].hnum),
            .den     (rows_eff),
            .rem_out (h_rem_o[g]),
            .num_out (h_num_o[g])
        );
    end

    // stage 1: split position, magnitude for the modulo, clamp-mode frame
    assign p_hi  = item_reg[S_MUL].pos[POS_W-1:FRAC_BITS];
    assign p_mag = item_reg[S_MUL].pos[POS_W-1] ? (~p_hi + HI_W'(1)) : p_hi;

    always_comb
    begin
        item_next[S_PREP]       = item_reg[S_MUL];
        item_next[S_PREP].neg   = item_reg[S_MUL].pos[POS_W-1];
        item_next[S_PREP].lo_nz = |item_reg[S_MUL].pos[FRAC_BITS-1:0];
        item_next[S_PREP].mnum  = MOD_NUM_W'(p_mag);
        item_next[S_PREP].mrem  = '0;
        if (item_reg[S_MUL].pos[POS_W-1])
            item_next[S_PREP].cf = '0;
        else if (p_hi >= HI_W'(fcs))
            item_next[S_PREP].cf = fcs_m1;
        else
            item_next[S_PREP].cf = p_hi[FRAME_W-1:0];
        item_next[S_PREP].wrem = w_rem_o[0];
        item_next[S_PREP].wnum = w_num_o[0];
        item_next[S_PREP].hrem = h_rem_o[0];
        item_next[S_PREP].hnum = h_num_o[0];
    end

    // modulo stages: |hi| mod divisor
    for (genvar g = 0; g < MOD_GROUPS; g++)
    begin : g_mod
        ssfs_div_steps #(
            .NUM_W (MOD_NUM_W),
            .DEN_W (DV_W),
            .STEPS (MOD_STEPS)
        ) u_mdiv (
            .rem_in  (item_reg[S_MOD0+g-1].mrem),
            .num_in  (item_reg[S_MOD0+g-1].mnum),
            .den     (dv_eff),
            .rem_out (mod_rem_o[g]),
            .num_out (mod_num_o[g])
        );

        if (g + 1 < DIM_GROUPS)
        begin : g_with_dim
            always_comb
            begin
                item_next[S_MOD0+g]      = item_reg[S_MOD0+g-1];
                item_next[S_MOD0+g].mrem = mod_rem_o[g];
                item_next[S_MOD0+g].mnum = mod_num_o[g];
                item_next[S_MOD0+g].wrem = w_rem_o[g+1];
                item_next[S_MOD0+g].wnum = w_num_o[g+1];
                item_next[S_MOD0+g].hrem = h_rem_o[g+1];
                item_next[S_MOD0+g].hnum = h_num_o[g+1];
            end
        end
        else
        begin : g_mod_only
            always_comb
            begin
                item_next[S_MOD0+g]      = item_reg[S_MOD0+g-1];
                item_next[S_MOD0+g].mrem = mod_rem_o[g];
                item_next[S_MOD0+g].mnum = mod_num_o[g];
            end
        end
    end

    // fold: floored remainder, then loop / ping-pong / clamp, then last-frame clamp
    assign fm = (item_reg[S_FOLD-1].neg && item_reg[S_FOLD-1].mrem != '0) ?
                (dv_eff - item_reg[S_FOLD-1].mrem) : item_reg[S_FOLD-1].mrem;

    always_comb
    begin
        case (mode_reg)
            MODE_LOOP:
                fold_f = fm;
            MODE_PINGPONG:
            begin
                if (fm >= DV_W'(fcs))
                    fold_f = {fcs, 1'b0} - fm - DV_W'(item_reg[S_FOLD-1].lo_nz);
                else
                    fold_f = fm;
            end
            default:
                fold_f = DV_W'(item_reg[S_FOLD-1].cf);
        endcase
    end

    always_comb
    begin
        item_next[S_FOLD]      = item_reg[S_FOLD-1];
        item_next[S_FOLD].frem = '0;
        if (fcs == '0)
            item_next[S_FOLD].fnum = '0;
        else if (fold_f > DV_W'(fcs_m1))
            item_next[S_FOLD].fnum = FDIV_NUM_W'(fcs_m1);
        else
            item_next[S_FOLD].fnum = FDIV_NUM_W'(fold_f);
    end

    // frame -> row (quotient) and column (remainder)
    for (genvar g = 0; g < FDIV_GROUPS; g++)
    begin : g_fdiv
        ssfs_div_steps #(
            .NUM_W (FDIV_NUM_W),
            .DEN_W (FC_W),
            .STEPS (FDIV_STEPS)
        ) u_fdiv (
            .rem_in  (item_reg[S_FDIV0+g-1].frem),
            .num_in  (item_reg[S_FDIV0+g-1].fnum),
            .den     (cols_eff),
            .rem_out (f_rem_o[g]),
            .num_out (f_num_o[g])
        );

        always_comb
        begin
            item_next[S_FDIV0+g]      = item_reg[S_FDIV0+g-1];
            item_next[S_FDIV0+g].frem = f_rem_o[g];
            item_next[S_FDIV0+g].fnum = f_num_o[g];
        end
    end

    // offsets: column * width, row * height
    always_comb
    begin
        item_next[S_MUL2]    = item_reg[S_MUL2-1];
        item_next[S_MUL2].px = PROD_W'(item_reg[S_MUL2-1].frem[FRAME_W-1:0])
                             * PROD_W'(item_reg[S_MUL2-1].wnum[UV_W-1:0]);
        item_next[S_MUL2].py = PROD_W'(item_reg[S_MUL2-1].fnum[FRAME_W-1:0])
                             * PROD_W'(item_reg[S_MUL2-1].hnum[UV_W-1:0]);
    end

    // output: add origin, saturate; mode none passes the rectangle through
    assign sum_x = XYSUM_W'(item_reg[S_OUT-1].ux) + XYSUM_W'(item_reg[S_OUT-1].px);
    assign sum_y = XYSUM_W'(item_reg[S_OUT-1].uy) + XYSUM_W'(item_reg[S_OUT-1].py);

    always_comb
    begin
        item_next[S_OUT] = item_reg[S_OUT-1];
        if (mode_reg == MODE_NONE)
        begin
            item_next[S_OUT].res.frame_row    = '0;
            item_next[S_OUT].res.frame_column = '0;
            item_next[S_OUT].res.out_x        = XY_W'(item_reg[S_OUT-1].ux);
            item_next[S_OUT].res.out_y        = XY_W'(item_reg[S_OUT-1].uy);
            item_next[S_OUT].res.out_width    = item_reg[S_OUT-1].uw;
            item_next[S_OUT].res.out_height   = item_reg[S_OUT-1].uh;
        end
        else
        begin
            item_next[S_OUT].res.frame_row    = item_reg[S_OUT-1].fnum[FRAME_W-1:0];
            item_next[S_OUT].res.frame_column = item_reg[S_OUT-1].frem[FRAME_W-1:0];
            item_next[S_OUT].res.out_x        = (sum_x > XYSUM_W'(XY_MAX)) ?
                                                XY_MAX : sum_x[XY_W-1:0];
            item_next[S_OUT].res.out_y        = (sum_y > XYSUM_W'(XY_MAX)) ?
                                                XY_MAX : sum_y[XY_W-1:0];
            item_next[S_OUT].res.out_width    = item_reg[S_OUT-1].wnum[UV_W-1:0];
            item_next[S_OUT].res.out_height   = item_reg[S_OUT-1].hnum[UV_W-1:0];
        end
    end

    // checks
    `SSFS_ASSERT_IMP(a_blocked_means_full, !item_ready, &valid_reg)
    `SSFS_ASSERT_IMP(a_none_frame_zero,
                     result_valid && mode_reg == MODE_NONE,
                     result.frame_row == '0 && result.frame_column == '0)
    `SSFS_ASSERT_IMP(a_column_in_sheet,
                     result_valid && mode_reg != MODE_NONE,
                     FC_W'(result.frame_column) < cols_eff)
    `SSFS_ASSERT_IMP(a_frame_in_range,
                     valid_reg[S_FOLD],
                     (fcs == '0 && item_reg[S_FOLD].fnum == '0) ||
                     (fcs != '0 && FC_W'(item_reg[S_FOLD].fnum) < fcs))

endmodule
